// ===== rtl/core/tps_pkg.sv =====
// Shared constants and register indexes for the triangle plane slicer.
`default_nettype none
package tps_pkg;

    localparam int COORD_BITS_DEF  = 32;
    localparam int T_FRAC_BITS_DEF = 24;
    localparam int CFG_IDX_BITS    = 3;

    // Reset value of normal_y: 1.0 in Q16.16
    localparam longint NORMAL_Y_RESET = 65536;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NORMAL_X = 3'd0,
        CFG_NORMAL_Y = 3'd1,
        CFG_NORMAL_Z = 3'd2,
        CFG_ANCHOR_X = 3'd3,
        CFG_ANCHOR_Y = 3'd4,
        CFG_ANCHOR_Z = 3'd5
    } t_cfg_idx;

endpackage
`default_nettype wire

// ===== rtl/core/tps_tri_if.sv =====
// Input channel: one triangle word per handshake.
`default_nettype none
interface tps_tri_if #(
    parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
    logic [COORD_BITS-1:0] first_z;
    logic [COORD_BITS-1:0] second_x;
    logic [COORD_BITS-1:0] second_y;
    logic [COORD_BITS-1:0] second_z;
    logic [COORD_BITS-1:0] third_x;
    logic [COORD_BITS-1:0] third_y;
    logic [COORD_BITS-1:0] third_z;
    logic                  last_triangle;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z, last_triangle,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z, last_triangle,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/tps_seg_if.sv =====
// Output channel: one segment word per handshake.
`default_nettype none
interface tps_seg_if #(
    parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] start_z;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COORD_BITS-1:0] end_z;
    logic                  last_result;

    modport source (
        output valid, hit, start_x, start_y, start_z, end_x, end_y, end_z,
               last_result,
        input  ready
    );
    modport sink (
        input  valid, hit, start_x, start_y, start_z, end_x, end_y, end_z,
               last_result,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/tps_dist.sv =====
// Vertex lane: signed plane distance N.(V-A), two stages.
`default_nettype none
module tps_dist #(
    parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic        [COORD_BITS-1:0] i_v      [3],
    input  wire logic signed [COORD_BITS-1:0] i_normal [3],
    input  wire logic signed [COORD_BITS-1:0] i_anchor [3],
    output logic             [COORD_BITS-1:0] o_v      [3],
    output logic             [2*COORD_BITS+2:0] o_d
);
    localparam int C  = COORD_BITS;
    localparam int DW = 2 * C + 3;

    logic signed [C:0]     n_diff [3];
    logic signed [2*C:0]   n_prod [3];
    logic signed [2*C:0]   r_prod [3];
    logic        [C-1:0]   r_v1   [3];
    logic        [C-1:0]   r_v2   [3];
    logic        [DW-1:0]  n_d;
    logic        [DW-1:0]  r_d;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_diff[c] = signed'({i_v[c][C-1], i_v[c]}) -
                        signed'({i_anchor[c][C-1], i_anchor[c]});
            n_prod[c] = i_normal[c] * n_diff[c];
        end
        n_d = {{2{r_prod[0][2*C]}}, r_prod[0]} +
              {{2{r_prod[1][2*C]}}, r_prod[1]} +
              {{2{r_prod[2][2*C]}}, r_prod[2]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= n_prod[c];
                r_v1[c]   <= i_v[c];
                r_v2[c]   <= r_v1[c];
            end
            r_d <= n_d;
        end
    end

    assign o_v = r_v2;
    assign o_d = r_d;
endmodule
`default_nettype wire

// ===== rtl/core/tps_edge.sv =====
// Edge lane: crossing test, bit-per-stage t division, interpolation, clamp.
`default_nettype none
module tps_edge #(
    parameter int COORD_BITS  = tps_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = tps_pkg::T_FRAC_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [COORD_BITS-1:0]     i_vj [3],
    input  wire logic [COORD_BITS-1:0]     i_vk [3],
    input  wire logic [2*COORD_BITS+2:0]   i_dj,
    input  wire logic [2*COORD_BITS+2:0]   i_dk,
    output logic                           o_cross,
    output logic [COORD_BITS-1:0]          o_p  [3]
);
    localparam int C  = COORD_BITS;
    localparam int T  = T_FRAC_BITS;
    localparam int DW = 2 * C + 3;
    localparam int RW = DW + 2;
    localparam int PW = C + 1 + T;

    logic [DW-1:0] w_aj, w_ak;
    logic [DW:0]   w_den;
    logic          w_cross;
    logic [C:0]    w_dl [3];

    logic [RW-1:0] r_rem [0:T];
    logic [DW:0]   r_den [0:T];
    logic [T-1:0]  r_q   [0:T];
    logic [C-1:0]  r_vj  [0:T][3];
    logic [C:0]    r_dl  [0:T][3];
    logic          r_cr  [0:T];

    logic [RW-1:0] n_sh  [1:T];
    logic          n_ge  [1:T];
    logic [RW-1:0] n_rem [1:T];

    logic [C:0]    n_mag  [3];
    logic [PW-1:0] n_prod [3];
    logic [PW-1:0] r_prod [3];
    logic          r_neg  [3];
    logic [C-1:0]  r_mvj  [3];
    logic          r_mcr;

    logic [C+1:0]  n_sum [3];
    logic [C-1:0]  n_p   [3];
    logic [C-1:0]  r_p   [3];
    logic          r_pcr;

    // setup: magnitudes, denominator, sign test
    always_comb begin
        w_aj    = i_dj[DW-1] ? (~i_dj + 1'b1) : i_dj;
        w_ak    = i_dk[DW-1] ? (~i_dk + 1'b1) : i_dk;
        w_den   = {1'b0, w_aj} + {1'b0, w_ak};
        w_cross = (|i_dj) && (|i_dk) && (i_dj[DW-1] ^ i_dk[DW-1]);
        for (int c = 0; c < 3; c++) begin
            w_dl[c] = {i_vk[c][C-1], i_vk[c]} - {i_vj[c][C-1], i_vj[c]};
        end
    end

    // one restoring-division bit per stage
    always_comb begin
        for (int i = 1; i <= T; i++) begin
            n_sh[i]  = {r_rem[i-1][RW-2:0], 1'b0};
            n_ge[i]  = n_sh[i] >= {1'b0, r_den[i-1]};
            n_rem[i] = n_ge[i] ? (n_sh[i] - {1'b0, r_den[i-1]}) : n_sh[i];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_mag[c]  = r_dl[T][c][C] ? (~r_dl[T][c] + 1'b1) : r_dl[T][c];
            n_prod[c] = PW'(n_mag[c]) * PW'(r_q[T]);
        end
    end

    // add or subtract the truncated step, then saturate
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = r_neg[c]
                ? ({{2{r_mvj[c][C-1]}}, r_mvj[c]} - {1'b0, r_prod[c][PW-1:T]})
                : ({{2{r_mvj[c][C-1]}}, r_mvj[c]} + {1'b0, r_prod[c][PW-1:T]});
            if ((n_sum[c][C+1] == n_sum[c][C]) && (n_sum[c][C] == n_sum[c][C-1])) begin
                n_p[c] = n_sum[c][C-1:0];
            end else if (n_sum[c][C+1]) begin
                n_p[c] = {1'b1, {(C-1){1'b0}}};
            end else begin
                n_p[c] = {1'b0, {(C-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {2'b00, w_aj};
            r_den[0] <= w_den;
            r_q[0]   <= '0;
            r_cr[0]  <= w_cross;
            for (int c = 0; c < 3; c++) begin
                r_vj[0][c] <= i_vj[c];
                r_dl[0][c] <= w_dl[c];
            end
            for (int i = 1; i <= T; i++) begin
                r_rem[i] <= n_rem[i];
                r_den[i] <= r_den[i-1];
                r_q[i]   <= {r_q[i-1][T-2:0], n_ge[i]};
                r_cr[i]  <= r_cr[i-1];
                for (int c = 0; c < 3; c++) begin
                    r_vj[i][c] <= r_vj[i-1][c];
                    r_dl[i][c] <= r_dl[i-1][c];
                end
            end
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= n_prod[c];
                r_neg[c]  <= r_dl[T][c][C];
                r_mvj[c]  <= r_vj[T][c];
                r_p[c]    <= n_p[c];
            end
            r_mcr <= r_cr[T];
            r_pcr <= r_mcr;
        end
    end

    assign o_cross = r_pcr;
    assign o_p     = r_p;
endmodule
`default_nettype wire

// ===== rtl/core/tps_merge.sv =====
// Merge of the edge lanes, one per triangle edge, into one segment, with output register and skid.
`default_nettype none
module tps_merge #(
    parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_vld,
    input  wire logic                  i_last,
    input  wire logic [2:0]            i_cross,
    input  wire logic [COORD_BITS-1:0] i_p [3][3],
    input  wire logic                  i_ready,
    output logic                       o_full,
    output logic                       o_valid,
    output logic                       o_hit,
    output logic                       o_last,
    output logic [COORD_BITS-1:0]      o_start [3],
    output logic [COORD_BITS-1:0]      o_end   [3]
);
    localparam int C = COORD_BITS;

    logic          n_hit;
    logic [C-1:0]  n_start [3];
    logic [C-1:0]  n_end   [3];

    logic          r_ov, r_full;
    logic          r_hit, r_last, r_shit, r_slast;
    logic [C-1:0]  r_start [3];
    logic [C-1:0]  r_end   [3];
    logic [C-1:0]  r_sstart [3];
    logic [C-1:0]  r_send   [3];

    always_comb begin
        n_hit = (i_cross == 3'b011) || (i_cross == 3'b101) || (i_cross == 3'b110);
        for (int c = 0; c < 3; c++) begin
            n_start[c] = '0;
            n_end[c]   = '0;
            if (n_hit) begin
                n_start[c] = i_cross[0] ? i_p[0][c] : i_p[1][c];
                n_end[c]   = (i_cross[0] && i_cross[1]) ? i_p[1][c] : i_p[2][c];
            end
        end
    end

    // pipeline stalls only while the skid holds a word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_full <= 1'b0;
        end else if (r_full) begin
            if (i_ready) begin
                r_hit   <= r_shit;
                r_last  <= r_slast;
                r_start <= r_sstart;
                r_end   <= r_send;
                r_full  <= 1'b0;
            end
        end else if (i_vld) begin
            if (!r_ov || i_ready) begin
                r_hit   <= n_hit;
                r_last  <= i_last;
                r_start <= n_start;
                r_end   <= n_end;
                r_ov    <= 1'b1;
            end else begin
                r_shit   <= n_hit;
                r_slast  <= i_last;
                r_sstart <= n_start;
                r_send   <= n_end;
                r_full   <= 1'b1;
            end
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_full  = r_full;
    assign o_valid = r_ov;
    assign o_hit   = r_hit;
    assign o_last  = r_last;
    assign o_start = r_start;
    assign o_end   = r_end;
endmodule
`default_nettype wire

// ===== rtl/core/triangle_plane_slice.sv =====
// Top level: triangle against plane slicer, with a vertex lane for each vertex and an edge lane for each edge.
//
//  channel   dir  handshake          word
//  i_tri     in   valid/ready        three vertices + last_triangle
//  o_seg     out  valid/ready        hit, segment start/end, last_result
//  i_cfg_*   in   write enable only  normal and anchor registers
//
// One triangle accepted per cycle while the skid is not full; t comes from the
// division pipeline that yields it one bit per stage.
// Reset clears the valid chain, output and skid; registers return to normal (0,1,0).
// A stalled output parks one word in the skid; input ready drops only while it is full.
`default_nettype none
module triangle_plane_slice #(
    parameter int COORD_BITS  = tps_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = tps_pkg::T_FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    tps_tri_if.sink                                i_tri,
    tps_seg_if.source                              o_seg,
    input  wire logic                              i_cfg_we,
    input  wire logic [tps_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [COORD_BITS-1:0]             i_cfg_data
);
    localparam int C    = COORD_BITS;
    localparam int DW   = 2 * C + 3;
    localparam int PIPE = T_FRAC_BITS + 5;

    logic signed [C-1:0] r_normal [3];
    logic signed [C-1:0] r_anchor [3];

    logic              w_en, w_full;
    logic [PIPE-1:0]   r_vld;
    logic [PIPE-1:0]   r_last;

    logic [C-1:0]  w_vin  [3][3];
    logic [C-1:0]  w_vd   [3][3];
    logic [DW-1:0] w_d    [3];
    logic [2:0]    w_cross;
    logic [C-1:0]  w_p    [3][3];
    logic          w_hit, w_last;
    logic [C-1:0]  w_start [3];
    logic [C-1:0]  w_end   [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal[0] <= '0;
            r_normal[1] <= C'(tps_pkg::NORMAL_Y_RESET);
            r_normal[2] <= '0;
            r_anchor[0] <= '0;
            r_anchor[1] <= '0;
            r_anchor[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (tps_pkg::t_cfg_idx'(i_cfg_idx))
                tps_pkg::CFG_NORMAL_X: r_normal[0] <= i_cfg_data;
                tps_pkg::CFG_NORMAL_Y: r_normal[1] <= i_cfg_data;
                tps_pkg::CFG_NORMAL_Z: r_normal[2] <= i_cfg_data;
                tps_pkg::CFG_ANCHOR_X: r_anchor[0] <= i_cfg_data;
                tps_pkg::CFG_ANCHOR_Y: r_anchor[1] <= i_cfg_data;
                tps_pkg::CFG_ANCHOR_Z: r_anchor[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en        = !w_full;
    assign i_tri.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE-2:0], i_tri.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_last <= {r_last[PIPE-2:0], i_tri.last_triangle};
        end
    end

    assign w_vin[0][0] = i_tri.first_x;
    assign w_vin[0][1] = i_tri.first_y;
    assign w_vin[0][2] = i_tri.first_z;
    assign w_vin[1][0] = i_tri.second_x;
    assign w_vin[1][1] = i_tri.second_y;
    assign w_vin[1][2] = i_tri.second_z;
    assign w_vin[2][0] = i_tri.third_x;
    assign w_vin[2][1] = i_tri.third_y;
    assign w_vin[2][2] = i_tri.third_z;

    for (genvar j = 0; j < 3; j++) begin : g_vtx
        tps_dist #(.COORD_BITS(C)) u_dist (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_v      (w_vin[j]),
            .i_normal (r_normal),
            .i_anchor (r_anchor),
            .o_v      (w_vd[j]),
            .o_d      (w_d[j])
        );
    end

    // edges in order first->second, second->third, third->first
    for (genvar j = 0; j < 3; j++) begin : g_edge
        tps_edge #(.COORD_BITS(C), .T_FRAC_BITS(T_FRAC_BITS)) u_edge (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_vj    (w_vd[j]),
            .i_vk    (w_vd[(j + 1) % 3]),
            .i_dj    (w_d[j]),
            .i_dk    (w_d[(j + 1) % 3]),
            .o_cross (w_cross[j]),
            .o_p     (w_p[j])
        );
    end

    tps_merge #(.COORD_BITS(C)) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[PIPE-1]),
        .i_last  (r_last[PIPE-1]),
        .i_cross (w_cross),
        .i_p     (w_p),
        .i_ready (o_seg.ready),
        .o_full  (w_full),
        .o_valid (o_seg.valid),
        .o_hit   (w_hit),
        .o_last  (w_last),
        .o_start (w_start),
        .o_end   (w_end)
    );

    assign o_seg.hit         = w_hit;
    assign o_seg.last_result = w_last;
    assign o_seg.start_x     = w_start[0];
    assign o_seg.start_y     = w_start[1];
    assign o_seg.start_z     = w_start[2];
    assign o_seg.end_x       = w_end[0];
    assign o_seg.end_y       = w_end[1];
    assign o_seg.end_z       = w_end[2];
endmodule
`default_nettype wire
